>>> hw/rtl/pl0_pkg.sv
package pl0_pkg;

    // Beat widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 56;

    // Opcodes
    localparam logic [3:0] OP_LIT = 4'd1;
    localparam logic [3:0] OP_OPR = 4'd2;
    localparam logic [3:0] OP_LOD = 4'd3;
    localparam logic [3:0] OP_STO = 4'd4;
    localparam logic [3:0] OP_CAL = 4'd5;
    localparam logic [3:0] OP_INC = 4'd6;
    localparam logic [3:0] OP_JMP = 4'd7;
    localparam logic [3:0] OP_JPC = 4'd8;
    localparam logic [3:0] OP_SYS = 4'd9;

    // OPR / SYS sub-operations
    localparam logic [31:0] OPR_RTN   = 32'd0;
    localparam logic [31:0] OPR_LAST  = 32'd10;
    localparam logic [31:0] SYS_WRITE = 32'd1;
    localparam logic [31:0] SYS_READ  = 32'd2;
    localparam logic [31:0] SYS_HALT  = 32'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    typedef enum logic [3:0] {
        ALU_NONE = 4'd0,
        ALU_ADD  = 4'd1,
        ALU_SUB  = 4'd2,
        ALU_MUL  = 4'd3,
        ALU_DIV  = 4'd4,
        ALU_EQ   = 4'd5,
        ALU_NE   = 4'd6,
        ALU_LT   = 4'd7,
        ALU_LE   = 4'd8,
        ALU_GT   = 4'd9,
        ALU_GE   = 4'd10
    } alu_op_t;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        KD_NOP, KD_LIT, KD_RTN, KD_ARITH, KD_LOD, KD_STO, KD_CAL,
        KD_INC, KD_JMP, KD_JPC, KD_SYSW, KD_SYSR, KD_SYSH, KD_HALTED
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WALK, ST_WALK_CAP, ST_RD_A, ST_CAP_A, ST_RD_B, ST_CAP_B,
        ST_ALU, ST_ALU_WAIT, ST_WCHECK, ST_WRITE, ST_COMMIT
    } state_t;

    function automatic alu_op_t alu_op_from_m(input logic [31:0] m);
        alu_op_t r;
        case (m[3:0])
            4'd1:    r = ALU_ADD;
            4'd2:    r = ALU_SUB;
            4'd3:    r = ALU_MUL;
            4'd4:    r = ALU_DIV;
            4'd5:    r = ALU_EQ;
            4'd6:    r = ALU_NE;
            4'd7:    r = ALU_LT;
            4'd8:    r = ALU_LE;
            4'd9:    r = ALU_GT;
            4'd10:   r = ALU_GE;
            default: r = ALU_NONE;
        endcase
        return r;
    endfunction

    function automatic kind_t decode_kind(input logic [3:0] op, input logic [31:0] m);
        kind_t k;
        case (op)
            OP_LIT: k = KD_LIT;
            OP_OPR: begin
                if (m == OPR_RTN)       k = KD_RTN;
                else if (m <= OPR_LAST) k = KD_ARITH;
                else                    k = KD_NOP;
            end
            OP_LOD: k = KD_LOD;
            OP_STO: k = KD_STO;
            OP_CAL: k = KD_CAL;
            OP_INC: k = KD_INC;
            OP_JMP: k = KD_JMP;
            OP_JPC: k = KD_JPC;
            OP_SYS: begin
                if (m == SYS_WRITE)     k = KD_SYSW;
                else if (m == SYS_READ) k = KD_SYSR;
                else if (m == SYS_HALT) k = KD_SYSH;
                else                    k = KD_NOP;
            end
            default: k = KD_NOP;
        endcase
        return k;
    endfunction

endpackage

>>> hw/rtl/pl0_stack_machine_execute_top.sv
// Each instruction runs in turn: decode, one registered stack read per static link
// followed and per stack word read, one write per stack word written, an ALU op or
// the bit-serial divide for OPR, then commit. Throughput: one instruction at a time;
// the stack RAM's single read port and the bit-serial divider set the pace.
// Reset (aresetn low, synchronous): base pointer 0, stack pointer -1, PC 0, not halted.
// Stack RAM contents are not cleared.
module pl0_stack_machine_execute_top import pl0_pkg::*; #(
    parameter int STACK_DEPTH = 1024,
    parameter int MAX_LEVEL   = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode[3:0], lex_level[7:4], operand_m[39:8], read_value[71:40]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // next_pc[15:0], write_valid[16], write_value[48:17], halted[49],
    // error_code[51:50], zero fill[55:52]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [9:0]           cfg_data
);

    localparam int AW = $clog2(STACK_DEPTH);

    state_t      state_reg, state_next;
    kind_t       kind_reg, kind_next;
    logic [31:0] sp_reg, sp_next;
    logic [31:0] bp_reg, bp_next;
    logic [15:0] pc_reg, pc_next;
    logic        halt_reg, halt_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] m_reg, m_next;
    logic [31:0] rv_reg, rv_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] opa_reg, opa_next;
    logic [31:0] opb_reg, opb_next;
    logic [31:0] res_reg, res_next;
    logic [1:0]  err_reg, err_next;
    logic        bad_reg, bad_next;
    logic [1:0]  wk_reg, wk_next;
    logic [AW-1:0] wbase_reg, wbase_next;
    logic          mvalid_reg, mvalid_next;
    logic [M_TDATA_W-1:0] mdata_reg, mdata_next;

    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [31:0]   rdata;
    alu_req_t      alu_req;
    alu_rsp_t      alu_rsp;

    logic [15:0]        pc_inc;
    logic signed [32:0] addr_a, addr_b, wbase33, wlast33;
    logic [1:0]         nwr;
    logic [1:0]         nrd;
    kind_t              dec_kind;
    logic [3:0]         lv_sat;
    logic               out_free;
    logic [31:0]        wval;
    logic               wvld;

    function automatic logic signed [32:0] s33(input logic [31:0] v);
        return $signed({v[31], v});
    endfunction

    function automatic logic inr(input logic signed [32:0] x);
        return (x >= 33'sd0) && (x < $signed(33'(STACK_DEPTH)));
    endfunction

    function automatic logic [1:0] reads_of(input kind_t k);
        logic [1:0] n;
        case (k)
            KD_RTN, KD_ARITH:                  n = 2'd2;
            KD_LOD, KD_STO, KD_JPC, KD_SYSW:   n = 2'd1;
            default:                           n = 2'd0;
        endcase
        return n;
    endfunction

    pl0_stack_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pl0_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    // Address and write-plan decode
    always_comb begin
        pc_inc   = pc_reg + 16'd3;
        dec_kind = decode_kind(s_tdata[3:0], s_tdata[39:8]);
        lv_sat   = (32'(s_tdata[7:4]) > 32'(MAX_LEVEL)) ? 4'(MAX_LEVEL) : s_tdata[7:4];
        nrd      = reads_of(kind_reg);
        out_free = !mvalid_reg || m_tready;

        case (kind_reg)
            KD_RTN:   addr_a = s33(bp_reg) + 33'sd1;
            KD_ARITH: addr_a = s33(sp_reg) - 33'sd1;
            KD_LOD:   addr_a = s33(base_reg) + s33(m_reg);
            default:  addr_a = s33(sp_reg);
        endcase
        addr_b = (kind_reg == KD_RTN) ? s33(bp_reg) + 33'sd2 : s33(sp_reg);

        case (kind_reg)
            KD_ARITH: wbase33 = s33(sp_reg) - 33'sd1;
            KD_STO:   wbase33 = s33(base_reg) + s33(m_reg);
            default:  wbase33 = s33(sp_reg) + 33'sd1;
        endcase
        case (kind_reg)
            KD_CAL:                                    nwr = 2'd3;
            KD_LIT, KD_ARITH, KD_LOD, KD_STO, KD_SYSR: nwr = 2'd1;
            default:                                   nwr = 2'd0;
        endcase
        wlast33 = wbase33 + $signed({31'd0, nwr}) - 33'sd1;

        case (kind_reg)
            KD_LIT:   wdata = m_reg;
            KD_SYSR:  wdata = rv_reg;
            KD_ARITH: wdata = res_reg;
            KD_CAL: begin
                case (wk_reg)
                    2'd0:    wdata = base_reg;
                    2'd1:    wdata = bp_reg;
                    default: wdata = {16'd0, pc_inc};
                endcase
            end
            default:  wdata = opa_reg;
        endcase
        waddr = wbase_reg + AW'(wk_reg);
    end

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        sp_next     = sp_reg;
        bp_next     = bp_reg;
        pc_next     = pc_reg;
        halt_next   = halt_reg;
        cnt_next    = cnt_reg;
        m_next      = m_reg;
        rv_next     = rv_reg;
        base_next   = base_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        res_next    = res_reg;
        err_next    = err_reg;
        bad_next    = bad_reg;
        wk_next     = wk_reg;
        wbase_next  = wbase_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        s_tready    = 1'b0;
        raddr       = base_reg[AW-1:0];
        we          = 1'b0;
        alu_req     = '{start: 1'b0, op: alu_op_from_m(m_reg), a: opa_reg, b: opb_reg};
        wval        = opa_reg;
        wvld        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    kind_next = halt_reg ? KD_HALTED : dec_kind;
                    cnt_next  = lv_sat;
                    m_next    = s_tdata[39:8];
                    rv_next   = s_tdata[71:40];
                    base_next = bp_reg;
                    err_next  = ERR_NONE;
                    bad_next  = 1'b0;
                    if (halt_reg)
                        state_next = ST_COMMIT;
                    else if (dec_kind == KD_LOD || dec_kind == KD_STO || dec_kind == KD_CAL)
                        state_next = ST_WALK;
                    else if (reads_of(dec_kind) != 2'd0)
                        state_next = ST_RD_A;
                    else
                        state_next = ST_WCHECK;
                end
            end
            // Static-link walk: one stack read per level
            ST_WALK: begin
                if (cnt_reg == 4'd0) begin
                    state_next = (nrd != 2'd0) ? ST_RD_A : ST_WCHECK;
                end else if (!inr(s33(base_reg))) begin
                    bad_next   = 1'b1;
                    state_next = ST_COMMIT;
                end else begin
                    raddr      = base_reg[AW-1:0];
                    state_next = ST_WALK_CAP;
                end
            end
            ST_WALK_CAP: begin
                base_next  = rdata;
                cnt_next   = cnt_reg - 4'd1;
                state_next = ST_WALK;
            end
            // Operand reads
            ST_RD_A: begin
                if (!inr(addr_a)) begin
                    bad_next   = 1'b1;
                    state_next = ST_COMMIT;
                end else begin
                    raddr      = addr_a[AW-1:0];
                    state_next = ST_CAP_A;
                end
            end
            ST_CAP_A: begin
                opa_next   = rdata;
                state_next = (nrd == 2'd2) ? ST_RD_B : ST_WCHECK;
            end
            ST_RD_B: begin
                if (!inr(addr_b)) begin
                    bad_next   = 1'b1;
                    state_next = ST_COMMIT;
                end else begin
                    raddr      = addr_b[AW-1:0];
                    state_next = ST_CAP_B;
                end
            end
            ST_CAP_B: begin
                opb_next   = rdata;
                state_next = (kind_reg == KD_ARITH) ? ST_ALU : ST_WCHECK;
            end
            ST_ALU: begin
                if (alu_op_from_m(m_reg) == ALU_DIV && opb_reg == 32'd0) begin
                    res_next   = 32'd0;
                    err_next   = ERR_DIV0;
                    state_next = ST_WCHECK;
                end else begin
                    alu_req.start = 1'b1;
                    state_next    = ST_ALU_WAIT;
                end
            end
            ST_ALU_WAIT: begin
                if (alu_rsp.done) begin
                    res_next   = alu_rsp.result;
                    state_next = ST_WCHECK;
                end
            end
            // All pushes/stores must be in range before any is written
            ST_WCHECK: begin
                wk_next    = 2'd0;
                wbase_next = wbase33[AW-1:0];
                if (nwr == 2'd0) begin
                    state_next = ST_COMMIT;
                end else if (!inr(wbase33) || !inr(wlast33)) begin
                    bad_next   = 1'b1;
                    state_next = ST_COMMIT;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                we      = 1'b1;
                wk_next = wk_reg + 2'd1;
                if (wk_reg == nwr - 2'd1) state_next = ST_COMMIT;
            end
            // Update registers and hand the result beat to the output stage
            ST_COMMIT: begin
                if (out_free) begin
                    state_next  = ST_IDLE;
                    mvalid_next = 1'b1;
                    if (kind_reg == KD_HALTED) begin
                        mdata_next = {4'd0, ERR_NONE, 1'b1, 32'd0, 1'b0, pc_reg};
                    end else if (bad_reg) begin
                        pc_next    = pc_inc;
                        mdata_next = {4'd0, ERR_RANGE, halt_reg, 32'd0, 1'b0, pc_inc};
                    end else begin
                        pc_next = pc_inc;
                        case (kind_reg)
                            KD_LIT, KD_LOD, KD_SYSR: sp_next = sp_reg + 32'd1;
                            KD_ARITH, KD_STO:        sp_next = sp_reg - 32'd1;
                            KD_JPC: begin
                                sp_next = sp_reg - 32'd1;
                                if (opa_reg == 32'd0) pc_next = m_reg[15:0];
                            end
                            KD_SYSW: begin
                                sp_next = sp_reg - 32'd1;
                                wvld    = 1'b1;
                            end
                            KD_RTN: begin
                                bp_next = opa_reg;
                                pc_next = opb_reg[15:0];
                                sp_next = bp_reg - 32'd1;
                            end
                            KD_CAL: begin
                                bp_next = sp_reg + 32'd1;
                                pc_next = m_reg[15:0];
                            end
                            KD_INC:  sp_next   = sp_reg + m_reg;
                            KD_JMP:  pc_next   = m_reg[15:0];
                            KD_SYSH: halt_next = 1'b1;
                            default: ;
                        endcase
                        mdata_next = {4'd0, err_reg, halt_next,
                                      wvld ? wval : 32'd0, wvld, pc_next};
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Configuration write (the user must write only while idle; the block does not enforce it)
        if (cfg_valid) begin
            bp_next = {22'd0, cfg_data};
            sp_next = {22'd0, cfg_data} - 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sp_reg     <= '1;
            bp_reg     <= '0;
            pc_reg     <= '0;
            halt_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            bp_reg     <= bp_next;
            pc_reg     <= pc_next;
            halt_reg   <= halt_next;
            mvalid_reg <= mvalid_next;
        end
        kind_reg  <= kind_next;
        cnt_reg   <= cnt_next;
        m_reg     <= m_next;
        rv_reg    <= rv_next;
        base_reg  <= base_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        res_reg   <= res_next;
        err_reg   <= err_next;
        bad_reg   <= bad_next;
        wk_reg    <= wk_next;
        wbase_reg <= wbase_next;
        mdata_reg <= mdata_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;

endmodule

>>> hw/rtl/pl0_alu.sv
module pl0_alu import pl0_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [31:0] res_reg, res_next;

    logic signed [31:0] sa, sb;
    logic [32:0]        trial;
    logic [32:0]        diff;

    assign sa = $signed(req.a);
    assign sb = $signed(req.b);

    // Registered result for the other ops, or load and run of the restoring divider (one quotient bit a cycle)
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, dvs_reg};

        if (busy_reg) begin
            quo_next = {quo_reg[30:0], ~diff[32]};
            rem_next = diff[32] ? trial[31:0] : diff[31:0];
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (32'd0 - {quo_reg[30:0], ~diff[32]})
                                    : {quo_reg[30:0], ~diff[32]};
            end
        end else if (req.start) begin
            case (req.op)
                ALU_ADD: begin res_next = req.a + req.b;              done_next = 1'b1; end
                ALU_SUB: begin res_next = req.a - req.b;              done_next = 1'b1; end
                ALU_MUL: begin res_next = req.a * req.b;              done_next = 1'b1; end
                ALU_EQ:  begin res_next = {31'd0, sa == sb};          done_next = 1'b1; end
                ALU_NE:  begin res_next = {31'd0, sa != sb};          done_next = 1'b1; end
                ALU_LT:  begin res_next = {31'd0, sa <  sb};          done_next = 1'b1; end
                ALU_LE:  begin res_next = {31'd0, sa <= sb};          done_next = 1'b1; end
                ALU_GT:  begin res_next = {31'd0, sa >  sb};          done_next = 1'b1; end
                ALU_GE:  begin res_next = {31'd0, sa >= sb};          done_next = 1'b1; end
                ALU_DIV: begin
                    busy_next = 1'b1;
                    cnt_next  = 5'd31;
                    rem_next  = 32'd0;
                    quo_next  = req.a[31] ? 32'd0 - req.a : req.a;
                    dvs_next  = req.b[31] ? 32'd0 - req.b : req.b;
                    neg_next  = req.a[31] ^ req.b[31];
                end
                default: begin res_next = 32'd0; done_next = 1'b1; end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

>>> hw/rtl/pl0_stack_ram.sv
module pl0_stack_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sim/pl0_execute_checker.sv
module pl0_execute_checker import pl0_pkg::*; #(
    parameter int STACK_DEPTH = 1024,
    parameter int MAX_LEVEL   = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [9:0]           cfg_data,
    output int                   fails,
    output int                   pending,
    output int                   n_checked
);

    // Shadow machine state
    logic [31:0] stack_mem [0:STACK_DEPTH-1];
    logic [31:0] base_ptr;
    logic [31:0] top_ptr;
    logic [15:0] pc_q;
    logic        halt_q;

    logic [M_TDATA_W-1:0] expected_results [$];

    function automatic logic [31:0] stack_rd(input longint i, inout bit bad);
        if (i < 0 || i >= STACK_DEPTH) begin
            bad = 1'b1;
            return 32'd0;
        end
        return stack_mem[i];
    endfunction

    function automatic longint follow_links(input longint b0, input int levels, inout bit bad);
        longint b;
        b = b0;
        for (int k = 0; k < levels; k++) begin
            if (b < 0 || b >= STACK_DEPTH) begin
                bad = 1'b1;
                return 0;
            end
            b = longint'($signed(stack_mem[b]));
        end
        return b;
    endfunction

    // Executes one instruction on the shadow state, returns the result beat
    function automatic logic [M_TDATA_W-1:0] execute_instr(input logic [S_TDATA_W-1:0] d);
        logic [3:0]  op;
        int          lv;
        logic [31:0] m, rv, res, wval, x, y;
        logic [15:0] pc_inc, npc;
        longint      sp, bp, ns, nb, b, mi, a, c, q;
        longint      widx [3];
        logic [31:0] wdat [3];
        int          nwr;
        bit          bad, wv, nh;
        logic [1:0]  err;
        if (halt_q)
            return {4'd0, ERR_NONE, 1'b1, 32'd0, 1'b0, pc_q};
        op = d[3:0];
        lv = int'(d[7:4]);
        if (lv > MAX_LEVEL) lv = MAX_LEVEL;
        m  = d[39:8];
        rv = d[71:40];
        mi = longint'($signed(m));
        pc_inc = pc_q + 16'd3;
        npc = pc_inc;
        sp = longint'($signed(top_ptr));
        bp = longint'($signed(base_ptr));
        ns = sp; nb = bp;
        nwr = 0; bad = 0; wv = 0; nh = 0; wval = 0; res = 0; err = ERR_NONE;
        case (op)
            OP_LIT: begin
                widx[0] = sp + 1; wdat[0] = m; nwr = 1; ns = sp + 1;
            end
            OP_OPR: begin
                if (m == OPR_RTN) begin
                    nb  = longint'($signed(stack_rd(bp + 1, bad)));
                    npc = stack_rd(bp + 2, bad);
                    ns  = bp - 1;
                end else if (m <= OPR_LAST) begin
                    x = stack_rd(sp - 1, bad);
                    y = stack_rd(sp, bad);
                    a = longint'($signed(x));
                    c = longint'($signed(y));
                    case (alu_op_t'(m[3:0]))
                        ALU_ADD: res = x + y;
                        ALU_SUB: res = x - y;
                        ALU_MUL: res = x * y;
                        ALU_DIV: begin
                            if (c == 0) begin
                                res = 0;
                                err = ERR_DIV0;
                            end else begin
                                q = a / c;
                                res = q[31:0];
                            end
                        end
                        ALU_EQ:  res = {31'd0, a == c};
                        ALU_NE:  res = {31'd0, a != c};
                        ALU_LT:  res = {31'd0, a < c};
                        ALU_LE:  res = {31'd0, a <= c};
                        ALU_GT:  res = {31'd0, a > c};
                        default: res = {31'd0, a >= c};
                    endcase
                    widx[0] = sp - 1; wdat[0] = res; nwr = 1; ns = sp - 1;
                end
            end
            OP_LOD: begin
                b = follow_links(bp, lv, bad);
                if (!bad) res = stack_rd(b + mi, bad);
                widx[0] = sp + 1; wdat[0] = res; nwr = 1; ns = sp + 1;
            end
            OP_STO: begin
                b = follow_links(bp, lv, bad);
                res = stack_rd(sp, bad);
                widx[0] = b + mi; wdat[0] = res; nwr = 1; ns = sp - 1;
            end
            OP_CAL: begin
                b = follow_links(bp, lv, bad);
                widx[0] = sp + 1; wdat[0] = b[31:0];
                widx[1] = sp + 2; wdat[1] = bp[31:0];
                widx[2] = sp + 3; wdat[2] = {16'd0, pc_inc};
                nwr = 3;
                nb = sp + 1; npc = m[15:0];
            end
            OP_INC: ns = sp + mi;
            OP_JMP: npc = m[15:0];
            OP_JPC: begin
                if (stack_rd(sp, bad) == 32'd0) npc = m[15:0];
                ns = sp - 1;
            end
            OP_SYS: begin
                if (m == SYS_WRITE) begin
                    wval = stack_rd(sp, bad); wv = 1; ns = sp - 1;
                end else if (m == SYS_READ) begin
                    widx[0] = sp + 1; wdat[0] = rv; nwr = 1; ns = sp + 1;
                end else if (m == SYS_HALT) begin
                    nh = 1;
                end
            end
            default: ;
        endcase
        for (int k = 0; k < nwr; k++)
            if (widx[k] < 0 || widx[k] >= STACK_DEPTH) bad = 1;
        if (bad) begin
            // abandoned step: only the counter moves on
            err = ERR_RANGE; wv = 0; wval = 0;
            pc_q = pc_inc;
        end else begin
            for (int k = 0; k < nwr; k++) stack_mem[widx[k]] = wdat[k];
            top_ptr  = ns[31:0];
            base_ptr = nb[31:0];
            pc_q     = npc;
            if (nh) halt_q = 1'b1;
        end
        return {4'd0, err, halt_q, wv ? wval : 32'd0, wv, pc_q};
    endfunction

    assign pending = expected_results.size();

    // Watch the channels: compare results first, then predict the new instruction
    always @(posedge aclk) begin
        logic [M_TDATA_W-1:0] exp_beat;
        if (!aresetn) begin
            base_ptr <= 32'd0;
            top_ptr  <= 32'hFFFF_FFFF;
            pc_q     <= 16'd0;
            halt_q   <= 1'b0;
            fails    <= 0;
            n_checked <= 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked <= n_checked + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_tdata);
                    fails <= fails + 1;
                end else begin
                    exp_beat = expected_results.pop_front();
                    if (exp_beat[15:0] !== m_tdata[15:0] || exp_beat[16] !== m_tdata[16] ||
                        exp_beat[48:17] !== m_tdata[48:17] || exp_beat[49] !== m_tdata[49] ||
                        exp_beat[51:50] !== m_tdata[51:50]) begin
                        $display("%0t: mismatch pc/wv/wval/halt/err exp %h %b %h %b %0d",
                                 $time, exp_beat[15:0], exp_beat[16], exp_beat[48:17],
                                 exp_beat[49], exp_beat[51:50]);
                        $display("%0t:                             got %h %b %h %b %0d",
                                 $time, m_tdata[15:0], m_tdata[16], m_tdata[48:17],
                                 m_tdata[49], m_tdata[51:50]);
                        fails <= fails + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                base_ptr = {22'd0, cfg_data};
                top_ptr  = {22'd0, cfg_data} - 32'd1;
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(execute_instr(s_tdata));
        end
    end

endmodule

>>> sim/pl0_stack_machine_execute_top_tb.sv
module pl0_stack_machine_execute_top_tb import pl0_pkg::*;;

    localparam int DEPTH     = 1024;
    localparam int N_RANDOM  = 700;
    localparam int CYC_LIMIT = 600000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [9:0]           cfg_data;

    int fails, pending, n_checked;
    int s_idle, m_idle;
    int n_sent, n_cfg;
    int cyc;
    bit hold_go, hold_seen;
    int hold_left;

    pl0_stack_machine_execute_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pl0_execute_checker u_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending),
        .n_checked (n_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc, pending);
            $display("[pl0_stack_machine_execute_top] ERROR");
            $finish;
        end
    end

    // Result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= m_idle);
        end
    end

    function automatic logic [S_TDATA_W-1:0] instr(input logic [3:0] op, input logic [3:0] lv,
                                                   input logic [31:0] m, input logic [31:0] rv);
        return {rv, m, lv, op};
    endfunction

    task automatic send(input logic [S_TDATA_W-1:0] d);
        while ($urandom_range(99) < s_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        n_sent++;
    endtask

    // Registers change only once the block has drained
    task automatic set_base(input logic [9:0] v);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    function automatic logic [31:0] some_value();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd0;
            3:       return $urandom;
            default: return 32'($urandom_range(20)) - 32'd6;
        endcase
    endfunction

    // Mostly well-formed instructions; halt is kept back for the end
    function automatic logic [S_TDATA_W-1:0] random_instr();
        int          r;
        logic [3:0]  lv;
        logic [31:0] m;
        r  = $urandom_range(99);
        lv = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(2));
        m  = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(5));
        if (r < 15)      return instr(OP_LIT, 4'($urandom), some_value(), $urandom);
        else if (r < 40) return instr(OP_OPR, 4'($urandom),
                                      ($urandom_range(9) == 0) ? $urandom
                                                               : 32'($urandom_range(10)),
                                      $urandom);
        else if (r < 50) return instr(OP_LOD, lv, m, $urandom);
        else if (r < 58) return instr(OP_STO, lv, m, $urandom);
        else if (r < 64) return instr(OP_CAL, lv, $urandom, $urandom);
        else if (r < 72) return instr(OP_INC, 4'($urandom),
                                      ($urandom_range(9) == 0) ? $urandom
                                                               : 32'($urandom_range(8)) - 32'd3,
                                      $urandom);
        else if (r < 78) return instr(OP_JMP, 4'($urandom), $urandom, $urandom);
        else if (r < 86) return instr(OP_JPC, 4'($urandom), $urandom, $urandom);
        else if (r < 95) begin
            m = ($urandom_range(4) == 0) ? (($urandom_range(1) == 0) ? 32'd0 : $urandom | 32'd4)
                                         : (($urandom_range(1) == 0) ? SYS_WRITE : SYS_READ);
            if (m == SYS_HALT) m = 32'd4;
            return instr(OP_SYS, 4'($urandom), m, $urandom);
        end else begin
            r = $urandom_range(6);
            return instr((r == 0) ? 4'd0 : 4'(9 + r), 4'($urandom), $urandom, $urandom);
        end
    endfunction

    logic [9:0] bases [4];

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        hold_go   = 1'b0;
        cyc = 0; n_sent = 0; n_cfg = 0;
        s_idle = 9;
        m_idle = 53;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole stack so no later read touches an unwritten word
        set_base(10'd0);
        for (int i = 0; i < DEPTH; i++)
            send(instr(OP_LIT, 4'($urandom), $urandom, $urandom));
        // one push past the top
        send(instr(OP_LIT, 4'd0, 32'd1, 32'd0));

        // Directed: wrap, overflow, divide by zero, compares, calls, range errors
        set_base(10'd5);
        send(instr(OP_LIT, 4'd0, 32'h7FFF_FFFF, 32'd0));
        send(instr(OP_LIT, 4'd0, 32'd1, 32'd0));
        send(instr(OP_OPR, 4'd0, 32'd1, 32'd0));
        send(instr(OP_LIT, 4'd0, 32'h8000_0000, 32'd0));
        send(instr(OP_LIT, 4'd0, 32'hFFFF_FFFF, 32'd0));
        send(instr(OP_OPR, 4'd0, 32'd4, 32'd0));
        send(instr(OP_LIT, 4'd0, 32'd0, 32'd0));
        send(instr(OP_OPR, 4'd0, 32'd4, 32'd0));
        send(instr(OP_LIT, 4'd0, 32'hFFFF_FFFB, 32'd0));
        send(instr(OP_OPR, 4'd0, 32'd7, 32'd0));
        send(instr(OP_OPR, 4'd0, 32'd11, 32'd0));
        send(instr(OP_SYS, 4'd0, SYS_WRITE, 32'd0));
        send(instr(OP_SYS, 4'd0, SYS_READ, 32'h8000_0001));
        send(instr(OP_SYS, 4'd0, 32'd0, 32'd0));
        send(instr(OP_CAL, 4'd0, 32'h0001_2345, 32'd0));
        send(instr(OP_LOD, 4'd1, 32'd0, 32'd0));
        send(instr(OP_LOD, 4'd15, 32'd0, 32'd0));
        send(instr(OP_STO, 4'd0, 32'h7FFF_FFFF, 32'd0));
        send(instr(OP_STO, 4'd1, 32'd0, 32'd0));
        send(instr(OP_OPR, 4'd0, OPR_RTN, 32'd0));
        send(instr(OP_INC, 4'd0, 32'hFFFF_FFFF, 32'd0));
        send(instr(OP_JMP, 4'd0, 32'hFFFF_FFFF, 32'd0));
        send(instr(OP_JPC, 4'd0, 32'h0000_0030, 32'd0));
        send(instr(4'd15, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        set_base(10'd1023);
        send(instr(OP_LIT, 4'd0, 32'd9, 32'd0));
        send(instr(OP_INC, 4'd0, 32'h8000_0000, 32'd0));

        // Random phases with fresh base pointers now and then
        bases = '{10'd0, 10'd1023, 10'd512, 10'd3};
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                s_idle = 53;
                m_idle = 9;
            end
            if (i == 2 * N_RANDOM / 3) begin
                s_idle = 0;
                m_idle = 0;
            end
            if (i == N_RANDOM / 2) hold_go = 1'b1;
            if (i % 60 == 0)
                set_base(($urandom_range(2) == 0) ? bases[$urandom_range(3)]
                                                  : 10'($urandom_range(1000, 8)));
            send(random_instr());
        end

        // Halt, then confirm the machine stays put
        send(instr(OP_SYS, 4'd0, SYS_HALT, 32'd0));
        send(instr(OP_LIT, 4'd0, 32'd1, 32'd0));
        send(instr(OP_JMP, 4'd0, 32'd0, 32'd0));
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("run: %0d instructions, %0d results checked, %0d base pointer writes",
                 n_sent, n_checked, n_cfg);
        $display("covered full stack fill, all opcodes, static links, range and divide errors, halt");
        if (fails == 0) begin
            $display("[pl0_stack_machine_execute_top] OK");
        end else begin
            $display("%0d mismatches", fails);
            $display("[pl0_stack_machine_execute_top] ERROR");
        end
        $finish;
    end

endmodule
